/* rtl/acld_pkg.sv */
// package for the ascii command line decoder
// result kinds, motor parse phases, keyword table and the result record
// no dependencies
`default_nettype none

package acld_pkg;

	// result kinds
	localparam logic [2:0] KIND_ARM      = 3'd0;
	localparam logic [2:0] KIND_STOP     = 3'd1;
	localparam logic [2:0] KIND_PING     = 3'd2;
	localparam logic [2:0] KIND_STATUS   = 3'd3;
	localparam logic [2:0] KIND_MOTOR    = 3'd4;
	localparam logic [2:0] KIND_BAD      = 3'd5;
	localparam logic [2:0] KIND_TOO_LONG = 3'd6;

	// motor syntax phases
	localparam logic [2:0] PH_EXPECT_M   = 3'd0;
	localparam logic [2:0] PH_AFTER_M    = 3'd1;
	localparam logic [2:0] PH_LEFT_SIGN  = 3'd2;
	localparam logic [2:0] PH_LEFT_DIG   = 3'd3;
	localparam logic [2:0] PH_BETWEEN    = 3'd4;
	localparam logic [2:0] PH_RIGHT_SIGN = 3'd5;
	localparam logic [2:0] PH_RIGHT_DIG  = 3'd6;
	localparam logic [2:0] PH_FAILED     = 3'd7;

	// characters
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_M     = 8'd77;

	// keyword table, text right-justified
	localparam int KW_COUNT = 5;
	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		48'("ARM"), 48'("STOP"), 48'("DISARM"), 48'("PING"), 48'("STATUS")
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd4, 3'd6, 3'd4, 3'd6};
	localparam logic [2:0] KW_KIND [KW_COUNT] = '{
		KIND_ARM, KIND_STOP, KIND_STOP, KIND_PING, KIND_STATUS
	};

	// magnitude saturation point
	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] left_value;
		logic signed [31:0] right_value;
	} result_t;

	// true when byte c sits at position pos of keyword k
	function automatic logic kw_hit(input int k, input logic [7:0] pos, input logic [7:0] c);
		int sh;
		logic [7:0] ch;
		sh = 0;
		ch = 8'd0;
		if (pos < 8'(KW_LEN[k])) begin
			sh = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
			ch = KW_TEXT[k][sh +: 8];
		end
		return (pos < 8'(KW_LEN[k])) && (ch == c);
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_SPACE);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

`default_nettype wire

/* rtl/acld_accum.sv */
// decimal accumulate step: magnitude times ten plus one digit, saturated at 2^31
// depends on acld_pkg
`default_nettype none

module acld_accum (
	input  wire logic [31:0] mag,
	input  wire logic [7:0]  digit_char,
	output logic      [31:0] mag_next
);
	import acld_pkg::*;

	logic [35:0] ext;
	logic [35:0] sum;
	logic [3:0]  digit;

	// times ten as two shifts, then add the digit
	always_comb begin
		ext   = {4'b0, mag};
		digit = 4'(digit_char - CH_ZERO);
		sum   = (ext << 3) + (ext << 1) + {32'b0, digit};
		if (sum > {4'b0, MAG_LIMIT}) begin
			mag_next = MAG_LIMIT;
		end else begin
			mag_next = sum[31:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/acld_parse.sv */
// running line parse state and the end-of-line result decision
// depends on acld_pkg and acld_accum
`default_nettype none

module acld_parse #(
	parameter int LINE_CAPACITY = 80
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [7:0]         rx_byte,
	output logic                    emit,
	output acld_pkg::result_t       res
);
	import acld_pkg::*;

	localparam int LW = $clog2(LINE_CAPACITY);

	logic [LW-1:0]       len_q, len_nxt;
	logic [KW_COUNT-1:0] cand_q, cand_nxt;
	logic [2:0]          phase_q, phase_nxt;
	logic [31:0]         left_q, left_nxt;
	logic [31:0]         right_q, right_nxt;
	logic [1:0]          sign_q, sign_nxt;
	logic                stop_q, stop_nxt;

	logic [7:0]  pos;
	logic        use_right;
	logic [31:0] acc_in, acc_out;
	logic        found;
	logic [2:0]  kw_kind_sel;

	// one shared accumulate unit for both values
	assign use_right = (phase_q == PH_BETWEEN) || (phase_q == PH_RIGHT_SIGN) ||
		(phase_q == PH_RIGHT_DIG);
	assign acc_in = use_right ? right_q : left_q;

	acld_accum u_accum (
		.mag       (acc_in),
		.digit_char(rx_byte),
		.mag_next  (acc_out)
	);

	assign pos = 8'(len_q);

	// keyword decision at line end, lowest index wins
	always_comb begin
		found       = 1'b0;
		kw_kind_sel = KIND_BAD;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (cand_q[k] && (stop_q || (8'(KW_LEN[k]) == pos))) begin
				found       = 1'b1;
				kw_kind_sel = KW_KIND[k];
			end
		end
	end

	// next state and result
	always_comb begin
		len_nxt   = len_q;
		cand_nxt  = cand_q;
		phase_nxt = phase_q;
		left_nxt  = left_q;
		right_nxt = right_q;
		sign_nxt  = sign_q;
		stop_nxt  = stop_q;
		emit      = 1'b0;
		res       = '0;
		res.kind  = KIND_BAD;

		if ((rx_byte == CH_LF) || (rx_byte == CH_CR)) begin
			// line end
			if (len_q != '0) begin
				emit = 1'b1;
				if (found) begin
					res.kind = kw_kind_sel;
				end else if (phase_q == PH_RIGHT_DIG) begin
					res.kind = KIND_MOTOR;
					res.left_value = sign_q[0] ? -left_q :
						(left_q[31] ? 32'h7FFF_FFFF : left_q);
					res.right_value = sign_q[1] ? -right_q :
						(right_q[31] ? 32'h7FFF_FFFF : right_q);
				end
				len_nxt   = '0;
				cand_nxt  = '1;
				phase_nxt = PH_EXPECT_M;
				left_nxt  = '0;
				right_nxt = '0;
				sign_nxt  = '0;
				stop_nxt  = 1'b0;
			end
		end else if (len_q >= LW'(LINE_CAPACITY - 1)) begin
			// overflow byte is dropped
			emit      = 1'b1;
			res.kind  = KIND_TOO_LONG;
			len_nxt   = '0;
			cand_nxt  = '1;
			phase_nxt = PH_EXPECT_M;
			left_nxt  = '0;
			right_nxt = '0;
			sign_nxt  = '0;
			stop_nxt  = 1'b0;
		end else begin
			len_nxt = len_q + 1'b1;
			if (!stop_q) begin
				if (rx_byte == CH_NUL) begin
					// nul ends the text of the line
					for (int k = 0; k < KW_COUNT; k++) begin
						if (8'(KW_LEN[k]) != pos) cand_nxt[k] = 1'b0;
					end
					if (phase_q != PH_RIGHT_DIG) phase_nxt = PH_FAILED;
					stop_nxt = 1'b1;
				end else begin
					for (int k = 0; k < KW_COUNT; k++) begin
						if (!kw_hit(k, pos, rx_byte)) cand_nxt[k] = 1'b0;
					end
					case (phase_q)
						PH_EXPECT_M: begin
							phase_nxt = (rx_byte == CH_M) ? PH_AFTER_M : PH_FAILED;
						end
						PH_AFTER_M, PH_BETWEEN: begin
							if (is_ws(rx_byte)) begin
								phase_nxt = phase_q;
							end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
								if (rx_byte == CH_MINUS) begin
									if (use_right) sign_nxt[1] = 1'b1;
									else sign_nxt[0] = 1'b1;
								end
								phase_nxt = use_right ? PH_RIGHT_SIGN : PH_LEFT_SIGN;
							end else if (is_digit(rx_byte)) begin
								if (use_right) right_nxt = acc_out;
								else left_nxt = acc_out;
								phase_nxt = use_right ? PH_RIGHT_DIG : PH_LEFT_DIG;
							end else begin
								phase_nxt = PH_FAILED;
							end
						end
						PH_LEFT_SIGN: begin
							if (is_digit(rx_byte)) begin
								left_nxt  = acc_out;
								phase_nxt = PH_LEFT_DIG;
							end else begin
								phase_nxt = PH_FAILED;
							end
						end
						PH_LEFT_DIG: begin
							if (is_digit(rx_byte)) begin
								left_nxt = acc_out;
							end else if (is_ws(rx_byte)) begin
								phase_nxt = PH_BETWEEN;
							end else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS)) begin
								if (rx_byte == CH_MINUS) sign_nxt[1] = 1'b1;
								phase_nxt = PH_RIGHT_SIGN;
							end else begin
								phase_nxt = PH_FAILED;
							end
						end
						PH_RIGHT_SIGN: begin
							if (is_digit(rx_byte)) begin
								right_nxt = acc_out;
								phase_nxt = PH_RIGHT_DIG;
							end else begin
								phase_nxt = PH_FAILED;
							end
						end
						PH_RIGHT_DIG: begin
							// trailing text after the second value is ignored
							if (is_digit(rx_byte)) right_nxt = acc_out;
							else stop_nxt = 1'b1;
						end
						default: begin
							phase_nxt = PH_FAILED;
						end
					endcase
				end
			end
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			cand_q  <= '1;
			phase_q <= PH_EXPECT_M;
			left_q  <= '0;
			right_q <= '0;
			sign_q  <= '0;
			stop_q  <= 1'b0;
		end else if (step) begin
			len_q   <= len_nxt;
			cand_q  <= cand_nxt;
			phase_q <= phase_nxt;
			left_q  <= left_nxt;
			right_q <= right_nxt;
			sign_q  <= sign_nxt;
			stop_q  <= stop_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/ascii_command_line_decoder.sv */
// ASCII command line decoder, top level: input register, parser, result register.
// Takes one received byte per item on the slave stream and gives one result per
// non-empty line on the master stream. Depends on acld_pkg and acld_parse.
//
// Channels: s_tdata carries one received byte; a CR or LF ends the line. Each
// non-empty line, and each byte that overflows the line buffer, gives one result
// item: the kind on m_tuser, the left and right values on m_tdata. Empty lines
// give nothing.
// Path: an accepted byte goes through the input register and then the result
// register before its result shows on m_tvalid.
// Throughput: one byte per cycle unless stalled; the parse state update, with the
// shared times-ten accumulate, sits between the input and the result register.
// Reset: arst_n clears the parse state, both registers empty, next byte starts a
// new line.
// Stall: while a result waits and m_tready is low, the byte in the input register
// holds and s_tready drops; when the waiting result is taken, s_tready follows in
// the same cycle.
`default_nettype none

module ascii_command_line_decoder #(
	parameter int LINE_CAPACITY = 80
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [63:0] m_tdata,   // [31:0] left_value, [63:32] right_value
	output logic      [2:0]  m_tuser    // [2:0] result_kind
);
	import acld_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       step;
	logic       emit;
	result_t    res;
	result_t    res_q;

	// a byte moves on when the result register can take whatever it makes
	assign out_free = !m_tvalid || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	acld_parse #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.rx_byte(byte_s1),
		.emit   (emit),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= res;
		end
	end

	assign m_tdata = {res_q.right_value, res_q.left_value};
	assign m_tuser = res_q.kind;

endmodule

`default_nettype wire
